// ----- src/pdh_pkg.sv -----
package pdh_pkg;

  localparam int DimDefault = 16;
  localparam int ValW = 24;
  localparam logic signed [63:0] S24Max = 64'sd8388607;
  localparam logic signed [63:0] S24Min = -64'sd8388608;
  localparam logic signed [63:0] S48Max = 64'sd140737488355327;
  localparam logic signed [63:0] S48Min = -64'sd140737488355328;
  localparam logic [16:0] OneQ = 17'd65536;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_ELEM = 2'd1,
    OP_DUMP = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_PRIOR   = 2'd0,
    REG_PSTEP   = 2'd1,
    REG_DSTEP   = 2'd2,
    REG_SPACING = 2'd3
  } reg_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ACC_MUL,
    S_ACC_ADD,
    S_T_INIT,
    S_SQRT,
    S_DIV_CT,
    S_DIV_DT,
    S_DIV_LOSS,
    S_DIV_COEF,
    S_G_MUL,
    S_G_SAT,
    S_W_RD,
    S_W_MUL,
    S_W_UPD,
    S_A_MUL,
    S_A_DIV,
    S_AL_MUL,
    S_AL_UPD,
    S_E_RD,
    S_E_LD,
    S_E_SEND
  } state_e;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] operand;
  } sqrt_req_t;

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    logic signed [23:0] r;
    if (v > S24Max) begin
      r = 24'sh7FFFFF;
    end else if (v < S24Min) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  function automatic logic [23:0] usat24(input logic [63:0] v);
    logic [23:0] r;
    if (v > 64'd8388607) begin
      r = 24'h7FFFFF;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

// ----- src/pdh_ram.sv -----
module pdh_ram #(
  parameter int Width = 24,
  parameter int Depth = 16,
  parameter int AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/pdh_div.sv -----
module pdh_div
  import pdh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  div_req_t    req_i,
  output logic        done_o,
  output logic [63:0] quot_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] quo_q, quo_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [32:0] rem_sh;
  logic        fits;

  // one quotient bit per cycle, restoring
  assign rem_sh = {rem_q, quo_q[63]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      rem_d = fits ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
      quo_d = {quo_q[62:0], fits};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ----- src/pdh_sqrt.sv -----
module pdh_sqrt
  import pdh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sqrt_req_t   req_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [63:0] n_q, n_d;
  logic [63:0] res_q, res_d;
  logic [63:0] bit_q, bit_d;
  logic [64:0] trial;

  assign trial = {1'b0, res_q} + {1'b0, bit_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    n_d    = n_q;
    res_d  = res_q;
    bit_d  = bit_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      n_d    = req_i.operand;
      res_d  = '0;
      bit_d  = 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      if ({1'b0, n_q} >= trial) begin
        n_d   = 64'({1'b0, n_q} - trial);
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[31:0];

endmodule

// ----- src/primal_dual_hinge_sgd_trainer_top.sv -----
// Load and dump requests are accepted in idle; a feature element passes through a
// multiply and an accumulate state. A sample end runs one training step: a square
// root, four divisions, then per weight two multiplies, an update and a division.
// Emission reads, loads and sends each averaged weight, waiting while output stalls.
// Reset clears counters, accumulator and sets alpha to 0.5; weight and feature
// memories hold nothing valid until loaded.
module primal_dual_hinge_sgd_trainer_top
  import pdh_pkg::*;
#(
  parameter int DIM = DimDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [3:0] elem_index, [27:4] value, [28] label_positive
  input  logic [31:0] s_axis_tdata_i,
  // [1:0] op
  input  logic [1:0]  s_axis_tuser_i,
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [23:0] avg_weight, [27:24] out_index
  output logic [31:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  localparam int AW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int Lanes = (DIM < 16) ? DIM : 16;

  state_e state_q, state_d;
  logic          run_q, run_d;
  logic [31:0]   step_q, step_d;
  logic [15:0]   rec_q, rec_d;
  logic signed [47:0] acc_q, acc_d;
  logic [16:0]   alpha_q, alpha_d;
  logic [15:0]   prior_q;
  logic [23:0]   pstep_q, dstep_q;
  logic [15:0]   spacing_q;
  logic          out_valid_q, out_valid_d;
  logic [AW-1:0] i_q, i_d;

  logic signed [23:0] val_q, val_d;
  logic          pos_q, pos_d, last_q, last_d, lt_q, lt_d;
  logic [23:0]   hinge_q, hinge_d;
  logic [31:0]   r_q, r_d;
  logic [23:0]   ct_q, ct_d, dt_q, dt_d, loss_q, loss_d, coeff_q, coeff_d, g_q, g_d;
  logic signed [23:0] w_q, w_d, avg_q, avg_d, wn_q, wn_d;
  logic signed [57:0] prod_q, prod_d;
  logic [23:0]   out_avg_q, out_avg_d;
  logic [3:0]    out_idx_q, out_idx_d;
  logic          out_last_q, out_last_d;

  logic          mul_en;
  logic signed [24:0] mul_a;
  logic signed [32:0] mul_b;

  logic          in_fire;
  op_e           in_op;
  logic [3:0]    in_idx;
  logic signed [23:0] in_val;
  logic          in_ok;

  logic          fb_we, wa_we;
  logic [AW-1:0] fb_waddr, wa_waddr, fb_raddr, wa_raddr;
  logic [23:0]   fb_wdata, fb_rdata;
  logic [47:0]   wa_wdata, wa_rdata;

  div_req_t      div_req;
  logic          div_done;
  logic [63:0]   div_quot;
  sqrt_req_t     sq_req;
  logic          sq_done;
  logic [31:0]   sq_root;

  logic signed [48:0] acc_ext, m_sgn;
  logic signed [23:0] margin, hinge_v;
  logic signed [63:0] acc_sum;
  logic [15:0]   pp;
  logic [16:0]   den17, cnum;
  logic signed [57:0] wprod;
  logic signed [57:0] avg_acc;
  logic [57:0]   avg_mag;
  logic signed [23:0] avg_new;
  logic signed [33:0] alpha_nx;
  logic [15:0]   rec_nx, spacing_eff;

  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign in_op   = op_e'(s_axis_tuser_i);
  assign in_idx  = s_axis_tdata_i[3:0];
  assign in_val  = s_axis_tdata_i[27:4];
  assign in_ok   = int'(in_idx) < DIM;

  assign acc_ext = 49'(acc_q);
  assign m_sgn   = pos_q ? acc_ext : -acc_ext;
  assign margin  = sat24(64'(m_sgn >>> 16));
  assign hinge_v = sat24(64'sd65536 - 64'(margin));
  assign acc_sum = 64'(acc_q) + 64'(prod_q);
  assign pp      = (prior_q == 16'd0) ? 16'd1 : prior_q;
  assign den17   = pos_q ? {1'b0, pp} : OneQ - {1'b0, pp};
  assign cnum    = pos_q ? alpha_q : OneQ - alpha_q;
  assign wprod   = pos_q ? prod_q : -prod_q;
  assign avg_acc = prod_q + 58'(wn_q);
  assign avg_mag = avg_acc[57] ? 58'(-avg_acc) : 58'(avg_acc);
  assign avg_new = avg_acc[57]
                 ? ((div_quot > 64'd8388608) ? 24'sh800000 : 24'(-div_quot[24:0]))
                 : sat24($signed(usat24(div_quot) == 24'h7FFFFF ? 64'd8388607 : div_quot));
  assign alpha_nx = pos_q ? 34'(alpha_q) + 34'(prod_q[47:16])
                          : 34'(alpha_q) - 34'(prod_q[47:16]);
  assign rec_nx      = rec_q + 16'd1;
  assign spacing_eff = (spacing_q == 16'd0) ? 16'd1 : spacing_q;

  assign prod_d = mul_en ? 58'(mul_a) * 58'(mul_b) : prod_q;

  always_comb begin
    state_d     = state_q;
    run_d       = run_q;
    step_d      = step_q;
    rec_d       = rec_q;
    acc_d       = acc_q;
    alpha_d     = alpha_q;
    out_valid_d = out_valid_q;
    i_d         = i_q;
    val_d       = val_q;
    pos_d       = pos_q;
    last_d      = last_q;
    lt_d        = lt_q;
    hinge_d     = hinge_q;
    r_d         = r_q;
    ct_d        = ct_q;
    dt_d        = dt_q;
    loss_d      = loss_q;
    coeff_d     = coeff_q;
    g_d         = g_q;
    w_d         = w_q;
    avg_d       = avg_q;
    wn_d        = wn_q;
    out_avg_d   = out_avg_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    mul_en      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    fb_we       = 1'b0;
    fb_waddr    = AW'(in_idx);
    fb_wdata    = in_val;
    fb_raddr    = i_q;
    wa_we       = 1'b0;
    wa_waddr    = AW'(in_idx);
    wa_wdata    = {in_val, in_val};
    wa_raddr    = i_q;
    div_req     = '0;
    sq_req      = '0;
    s_axis_tready_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        wa_raddr = AW'(in_idx);
        if (in_fire) begin
          val_d  = in_val;
          pos_d  = s_axis_tdata_i[28];
          last_d = s_axis_tlast_i;
          case (in_op)
            OP_LOAD: wa_we = in_ok;
            OP_ELEM: begin
              if (in_ok) begin
                fb_we   = 1'b1;
                state_d = S_ACC_MUL;
              end else if (s_axis_tlast_i) begin
                state_d = S_T_INIT;
              end
            end
            OP_DUMP: begin
              i_d     = '0;
              state_d = S_E_RD;
            end
            default: ;
          endcase
        end
      end
      S_ACC_MUL: begin
        mul_en  = 1'b1;
        mul_a   = 25'(val_q);
        mul_b   = 33'($signed(wa_rdata[23:0]));
        state_d = S_ACC_ADD;
      end
      S_ACC_ADD: begin
        if (acc_sum > S48Max) begin
          acc_d = S48Max[47:0];
        end else if (acc_sum < S48Min) begin
          acc_d = S48Min[47:0];
        end else begin
          acc_d = acc_sum[47:0];
        end
        state_d = last_q ? S_T_INIT : S_IDLE;
      end
      S_T_INIT: begin
        if (step_q != 32'hFFFF_FFFF) begin
          step_d = step_q + 32'd1;
        end
        lt_d    = margin < 24'sd65536;
        hinge_d = (margin < 24'sd65536) ? hinge_v : 24'd0;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        if (!run_q) begin
          sq_req.start   = 1'b1;
          sq_req.operand = {step_q, 32'd0};
          run_d = 1'b1;
        end else if (sq_done) begin
          r_d     = sq_root;
          run_d   = 1'b0;
          state_d = S_DIV_CT;
        end
      end
      S_DIV_CT: begin
        if (!run_q) begin
          div_req = '{start: 1'b1, num: {24'd0, pstep_q, 16'd0}, den: r_q};
          run_d = 1'b1;
        end else if (div_done) begin
          ct_d    = div_quot[23:0];
          run_d   = 1'b0;
          state_d = S_DIV_DT;
        end
      end
      S_DIV_DT: begin
        if (!run_q) begin
          div_req = '{start: 1'b1, num: {24'd0, dstep_q, 16'd0}, den: r_q};
          run_d = 1'b1;
        end else if (div_done) begin
          dt_d    = div_quot[23:0];
          run_d   = 1'b0;
          state_d = S_DIV_LOSS;
        end
      end
      S_DIV_LOSS: begin
        if (!run_q) begin
          div_req = '{start: 1'b1, num: {24'd0, hinge_q, 16'd0}, den: 32'(den17)};
          run_d = 1'b1;
        end else if (div_done) begin
          loss_d  = usat24(div_quot);
          run_d   = 1'b0;
          state_d = S_DIV_COEF;
        end
      end
      S_DIV_COEF: begin
        if (!run_q) begin
          div_req = '{start: 1'b1, num: {31'd0, cnum, 16'd0}, den: 32'(den17)};
          run_d = 1'b1;
        end else if (div_done) begin
          coeff_d = usat24(div_quot);
          run_d   = 1'b0;
          state_d = S_G_MUL;
        end
      end
      S_G_MUL: begin
        mul_en  = 1'b1;
        mul_a   = 25'({1'b0, ct_q});
        mul_b   = 33'({1'b0, coeff_q});
        state_d = S_G_SAT;
      end
      S_G_SAT: begin
        g_d     = usat24(64'(prod_q[57:16]));
        i_d     = '0;
        state_d = S_W_RD;
      end
      S_W_RD: state_d = S_W_MUL;
      S_W_MUL: begin
        mul_en  = 1'b1;
        mul_a   = 25'({1'b0, g_q});
        mul_b   = 33'($signed(fb_rdata));
        w_d     = wa_rdata[23:0];
        avg_d   = wa_rdata[47:24];
        state_d = S_W_UPD;
      end
      S_W_UPD: begin
        wn_d    = lt_q ? sat24(64'(w_q) + 64'(wprod >>> 16)) : w_q;
        state_d = S_A_MUL;
      end
      S_A_MUL: begin
        mul_en  = 1'b1;
        mul_a   = 25'(avg_q);
        mul_b   = 33'({1'b0, step_q - 32'd1});
        state_d = S_A_DIV;
      end
      S_A_DIV: begin
        if (!run_q) begin
          div_req = '{start: 1'b1, num: 64'(avg_mag), den: step_q};
          run_d = 1'b1;
        end else if (div_done) begin
          run_d    = 1'b0;
          wa_we    = 1'b1;
          wa_waddr = i_q;
          wa_wdata = {avg_new, wn_q};
          if (i_q == AW'(DIM - 1)) begin
            state_d = S_AL_MUL;
          end else begin
            i_d     = i_q + AW'(1);
            state_d = S_W_RD;
          end
        end
      end
      S_AL_MUL: begin
        mul_en  = 1'b1;
        mul_a   = 25'({1'b0, dt_q});
        mul_b   = 33'({1'b0, loss_q});
        state_d = S_AL_UPD;
      end
      S_AL_UPD: begin
        if (alpha_nx > 34'sd65536) begin
          alpha_d = OneQ;
        end else if (alpha_nx < 34'sd0) begin
          alpha_d = '0;
        end else begin
          alpha_d = alpha_nx[16:0];
        end
        acc_d = '0;
        i_d   = '0;
        if (rec_nx >= spacing_eff) begin
          rec_d   = '0;
          state_d = S_E_RD;
        end else begin
          rec_d   = rec_nx;
          state_d = S_IDLE;
        end
      end
      S_E_RD: state_d = S_E_LD;
      S_E_LD: begin
        out_avg_d   = wa_rdata[47:24];
        out_idx_d   = 4'(i_q);
        out_last_d  = i_q == AW'(Lanes - 1);
        out_valid_d = 1'b1;
        state_d     = S_E_SEND;
      end
      S_E_SEND: begin
        if (m_axis_tready_i) begin
          out_valid_d = 1'b0;
          if (i_q == AW'(Lanes - 1)) begin
            state_d = S_IDLE;
          end else begin
            i_d     = i_q + AW'(1);
            state_d = S_E_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      run_q       <= 1'b0;
      step_q      <= '0;
      rec_q       <= '0;
      acc_q       <= '0;
      alpha_q     <= 17'd32768;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      prior_q     <= 16'd32768;
      pstep_q     <= 24'd65536;
      dstep_q     <= 24'd65536;
      spacing_q   <= 16'd1;
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      step_q      <= step_d;
      rec_q       <= rec_d;
      acc_q       <= acc_d;
      alpha_q     <= alpha_d;
      out_valid_q <= out_valid_d;
      i_q         <= i_d;
      if (cfg_we_i) begin
        case (reg_e'(cfg_index_i))
          REG_PRIOR:   prior_q   <= cfg_data_i[15:0];
          REG_PSTEP:   pstep_q   <= cfg_data_i;
          REG_DSTEP:   dstep_q   <= cfg_data_i;
          REG_SPACING: spacing_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    pos_q      <= pos_d;
    last_q     <= last_d;
    lt_q       <= lt_d;
    hinge_q    <= hinge_d;
    r_q        <= r_d;
    ct_q       <= ct_d;
    dt_q       <= dt_d;
    loss_q     <= loss_d;
    coeff_q    <= coeff_d;
    g_q        <= g_d;
    w_q        <= w_d;
    avg_q      <= avg_d;
    wn_q       <= wn_d;
    prod_q     <= prod_d;
    out_avg_q  <= out_avg_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
  end

  pdh_ram #(.Width(24), .Depth(DIM), .AddrW(AW)) u_feat_ram (
    .clk_i   (clk_i),
    .we_i    (fb_we),
    .waddr_i (fb_waddr),
    .wdata_i (fb_wdata),
    .raddr_i (fb_raddr),
    .rdata_o (fb_rdata)
  );

  // upper half running average, lower half weight
  pdh_ram #(.Width(48), .Depth(DIM), .AddrW(AW)) u_wavg_ram (
    .clk_i   (clk_i),
    .we_i    (wa_we),
    .waddr_i (wa_waddr),
    .wdata_i (wa_wdata),
    .raddr_i (wa_raddr),
    .rdata_o (wa_rdata)
  );

  pdh_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  pdh_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sq_req),
    .done_o (sq_done),
    .root_o (sq_root)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, out_idx_q, out_avg_q};
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTHESIS
  a_valid_in_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> state_q == S_E_SEND)
    else $error("output valid outside send state");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !m_axis_tvalid_o)
    else $error("input taken while a result is pending");
  a_alpha_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alpha_q <= OneQ)
    else $error("dual variable out of range");
  a_dump_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_op == OP_DUMP) |=> state_q == S_E_RD)
    else $error("dump request did not start emission");
`endif

endmodule
